>>> hw/rtl/key_event_generator_fifo_top_defines.svh
// Assertion macros for the key event generator.
`ifndef KEY_EVENT_GENERATOR_FIFO_TOP_DEFINES_SVH
`define KEY_EVENT_GENERATOR_FIFO_TOP_DEFINES_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define KEG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define KEG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/keg_pkg.sv
// Shared types and constants for the key event generator.
package keg_pkg;

  localparam int NUM_KEYS_DEF   = 13;
  localparam int RING_DEPTH_DEF = 16;

  localparam int HOLD_W = 16;
  localparam int REP_W  = 8;
  localparam int CODE_W = 6;

  localparam logic [HOLD_W-1:0] LONG_TIME_RST    = 16'd100;
  localparam logic [REP_W-1:0]  REPEAT_SPEED_RST = 8'd0;

  localparam logic [CODE_W-1:0] CODE_PRESS   = 6'd1;
  localparam logic [CODE_W-1:0] CODE_RELEASE = 6'd2;
  localparam logic [CODE_W-1:0] CODE_LONG    = 6'd3;

  localparam logic REG_LONG_TIME    = 1'b0;
  localparam logic REG_REPEAT_SPEED = 1'b1;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_POP1   = 2'd1,
    OP_POP2   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PUSH2
  } state_t;

  typedef struct packed {
    logic              flag;
    logic [HOLD_W-1:0] hold;
    logic [REP_W-1:0]  rep;
  } key_entry_t;

endpackage

>>> hw/rtl/key_event_generator_fifo_top.sv
// Key event generator with per-key state memory and a two-reader event ring.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------------------
//   request  | start / busy        | op, key_index, pressed
//   result   | done (one cycle)    | key_code, key_state, events_added
//   config   | psel/penable/pready | paddr, pwdata, prdata
//
// A request passes through ST_EXEC, and also through ST_PUSH2 when a sample
// pushes two codes, since the event ring has one write port. The key memory
// and ring are read in the accept cycle and written back next. The result
// strobe comes in the cycle after the update; the next request is taken then
// unless in ST_PUSH2. Reset clears per-key state through valid bits at once.
`include "key_event_generator_fifo_top_defines.svh"

module key_event_generator_fifo_top #(
  parameter int NUM_KEYS   = keg_pkg::NUM_KEYS_DEF,
  parameter int RING_DEPTH = keg_pkg::RING_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  op,
  input  logic [3:0]                  key_index,
  input  logic                        pressed,
  output logic                        done,
  output logic [keg_pkg::CODE_W-1:0]  key_code,
  output logic                        key_state,
  output logic [1:0]                  events_added,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import keg_pkg::*;

  localparam int KEY_AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int PTR_W  = $clog2(RING_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

  state_t state, state_next;

  logic [HOLD_W-1:0] long_time;
  logic [REP_W-1:0]  repeat_speed;
  logic              cfg_wr;

  key_entry_t        key_mem [NUM_KEYS];
  logic [CODE_W-1:0] ring_mem [RING_DEPTH];
  logic [NUM_KEYS-1:0] key_valid;
  logic [NUM_KEYS-1:0] rep_valid;

  logic [PTR_W-1:0] wp, rp1, rp2;

  logic              accept;
  logic              in_range;
  logic [KEY_AW-1:0] addr;

  op_t               op_q;
  logic [KEY_AW-1:0] addr_q;
  logic [3:0]        idx_q;
  logic              down_q;
  logic              inr_q;
  logic              kv_q;
  logic              rv_q;
  key_entry_t        kent_q;
  logic [CODE_W-1:0] ring_q;
  logic [CODE_W-1:0] code2_q;

  logic              cur_flag;
  logic [HOLD_W-1:0] cur_hold;
  logic [REP_W-1:0]  cur_rep;
  logic [HOLD_W-1:0] hold_inc;
  logic [REP_W-1:0]  rep_inc;
  key_entry_t        kent_next;
  logic              push_press, push_rel, push_long, push_rep;
  logic              push1, push2;
  logic [CODE_W-1:0] base;
  logic [CODE_W-1:0] code1;
  logic              key_wr;
  logic              pop_sel, pop_empty;
  logic [PTR_W-1:0]  pop_ptr;

  assign accept   = start && !busy;
  assign in_range = {3'b000, key_index} < 7'(NUM_KEYS);
  assign addr     = KEY_AW'(key_index);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;

  always_comb begin
    case (paddr[2])
      REG_LONG_TIME:    prdata = {16'd0, long_time};
      REG_REPEAT_SPEED: prdata = {24'd0, repeat_speed};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      long_time    <= LONG_TIME_RST;
      repeat_speed <= REPEAT_SPEED_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_LONG_TIME:    long_time    <= pwdata[HOLD_W-1:0];
        REG_REPEAT_SPEED: repeat_speed <= pwdata[REP_W-1:0];
        default:          ;
      endcase
    end
  end

  // FSM
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept) state_next = ST_EXEC;
      ST_EXEC:  state_next = push2 ? ST_PUSH2 : ST_IDLE;
      ST_PUSH2: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    case (state)
      ST_IDLE: busy = 1'b0;
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Request capture and memory reads
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= op_t'(op);
      addr_q <= addr;
      idx_q  <= key_index;
      down_q <= pressed;
      inr_q  <= in_range;
      if (in_range) begin
        kent_q <= key_mem[addr];
        kv_q   <= key_valid[addr];
        rv_q   <= rep_valid[addr];
      end else begin
        kv_q <= 1'b0;
        rv_q <= 1'b0;
      end
      ring_q <= ring_mem[(op_t'(op) == OP_POP2) ? rp2 : rp1];
    end
  end

  // Key update
  always_comb begin
    cur_flag   = kv_q ? kent_q.flag : 1'b0;
    cur_hold   = kv_q ? kent_q.hold : '0;
    cur_rep    = rv_q ? kent_q.rep  : '0;
    hold_inc   = cur_hold + 1'b1;
    rep_inc    = cur_rep + 1'b1;
    kent_next  = '{flag: cur_flag, hold: cur_hold, rep: cur_rep};
    push_press = 1'b0;
    push_rel   = 1'b0;
    push_long  = 1'b0;
    push_rep   = 1'b0;
    if (down_q) begin
      kent_next.flag = 1'b1;
      push_press     = !cur_flag;
      if (long_time != '0) begin
        if (cur_hold < long_time) begin
          kent_next.hold = hold_inc;
          push_long      = (hold_inc == long_time);
        end else if (repeat_speed != '0) begin
          if (rep_inc >= repeat_speed) begin
            kent_next.rep = '0;
            push_rep      = 1'b1;
          end else begin
            kent_next.rep = rep_inc;
          end
        end
      end
    end else begin
      kent_next = '{flag: 1'b0, hold: '0, rep: '0};
      push_rel  = cur_flag;
    end
  end

  assign key_wr = (state == ST_EXEC) && (op_q == OP_SAMPLE) && inr_q;
  assign base   = CODE_W'({idx_q, 1'b0}) + CODE_W'(idx_q);
  assign push1  = key_wr && (push_press || push_rel || push_long || push_rep);
  assign push2  = key_wr && push_press && push_long;

  always_comb begin
    if (push_press)    code1 = base + CODE_PRESS;
    else if (push_rel) code1 = base + CODE_RELEASE;
    else if (push_long) code1 = base + CODE_LONG;
    else               code1 = base + CODE_PRESS;
  end

  always_ff @(posedge clk) begin
    if (key_wr) key_mem[addr_q] <= kent_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid <= '0;
      rep_valid <= '0;
    end else begin
      if (key_wr) key_valid[addr_q] <= 1'b1;
      if (cfg_wr) begin
        rep_valid <= '0;
      end else if (key_wr) begin
        rep_valid[addr_q] <= 1'b1;
      end
    end
  end

  // Event ring
  assign pop_sel   = (state == ST_EXEC) && ((op_q == OP_POP1) || (op_q == OP_POP2));
  assign pop_ptr   = (op_q == OP_POP2) ? rp2 : rp1;
  assign pop_empty = (pop_ptr == wp);

  always_ff @(posedge clk) begin
    if (push1) ring_mem[wp] <= code1;
    else if (state == ST_PUSH2) ring_mem[wp] <= code2_q;
  end

  always_ff @(posedge clk) begin
    if (push2) code2_q <= base + CODE_LONG;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp1 <= '0;
      rp2 <= '0;
    end else begin
      if (push1 || (state == ST_PUSH2)) wp <= (wp == PTR_LAST) ? '0 : wp + 1'b1;
      if (pop_sel && !pop_empty) begin
        if (op_q == OP_POP2) rp2 <= (rp2 == PTR_LAST) ? '0 : rp2 + 1'b1;
        else                 rp1 <= (rp1 == PTR_LAST) ? '0 : rp1 + 1'b1;
      end
      if ((state == ST_EXEC) && (op_q == OP_CLEAR)) rp1 <= wp;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= (state == ST_EXEC);
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      key_code     <= (pop_sel && !pop_empty) ? ring_q : '0;
      key_state    <= key_wr ? kent_next.flag : 1'b0;
      events_added <= {1'b0, push1} + {1'b0, push2};
    end
  end

  `KEG_ASSERT_NEXT(a_exec_done, state == ST_EXEC, done, "update not followed by result")
  `KEG_ASSERT_NEXT(a_accept_busy, accept, busy && (state == ST_EXEC), "request not taken")
  `KEG_ASSERT_NOW(a_sample_no_code, done && (events_added != 2'd0), key_code == '0,
                  "sample result carries a code")
  `KEG_ASSERT_NEXT(a_push2_origin, push2, state == ST_PUSH2, "second push lost")

endmodule

>>> bench/key_event_generator_fifo_top_test.sv
// Self-checking bench for the key event generator: request driver, result monitor, APB setup.
module key_event_generator_fifo_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import keg_pkg::*;

  localparam int KEYS  = NUM_KEYS_DEF;
  localparam int RING  = RING_DEPTH_DEF;
  localparam int PTR_W = $clog2(RING);
  localparam int PHASES = 7;
  localparam int LONG_HOLD_PHASE = 4;

  typedef struct packed {
    op_t        op;
    logic [3:0] key;
    logic       down;
  } request_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              state;
    logic [1:0]        added;
  } result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  op_t               op = OP_SAMPLE;
  logic [3:0]        key_index = '0;
  logic              pressed = 1'b0;
  logic              done;
  logic [CODE_W-1:0] key_code;
  logic              key_state;
  logic [1:0]        events_added;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  key_event_generator_fifo_top u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .key_index    (key_index),
    .pressed      (pressed),
    .done         (done),
    .key_code     (key_code),
    .key_state    (key_state),
    .events_added (events_added),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  request_t pending_requests[$];
  result_t  expected_results[$];

  int  mismatches = 0;
  int  results_checked = 0;
  int  requests_sent = 0;
  int  codes_pushed = 0;
  int  long_presses = 0;
  int  repeat_presses = 0;
  int  config_writes = 0;
  int  gap_left = 0;
  bit  idle_allowed = 1'b1;
  bit  hold_sender = 1'b0;
  bit  req_taken = 1'b0;

  logic              key_down     [KEYS] = '{default: 1'b0};
  logic [HOLD_W-1:0] hold_count   [KEYS] = '{default: '0};
  logic [REP_W-1:0]  repeat_count [KEYS] = '{default: '0};
  logic [CODE_W-1:0] ring         [RING] = '{default: '0};
  logic [PTR_W-1:0]  wr_ptr = '0;
  logic [PTR_W-1:0]  rd1_ptr = '0;
  logic [PTR_W-1:0]  rd2_ptr = '0;
  logic [HOLD_W-1:0] long_time_cfg = LONG_TIME_RST;
  logic [REP_W-1:0]  repeat_speed_cfg = REPEAT_SPEED_RST;

  int phase_long_time [PHASES] = '{1, 3, 0, 65535, 2, 5, 4};
  int phase_repeat    [PHASES] = '{1, 2, 5, 0, 255, 3, 1};
  int phase_items     [PHASES] = '{80, 110, 90, 70, 30, 110, 120};

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 50) $display("%0t: mismatch: %s", $realtime, msg);
  endtask

  function automatic logic [PTR_W-1:0] ring_next(logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic void ring_push(logic [CODE_W-1:0] c);
    ring[wr_ptr] = c;
    wr_ptr = ring_next(wr_ptr);
    codes_pushed++;
  endfunction

  function automatic logic [CODE_W-1:0] ring_pop(bit second);
    logic [PTR_W-1:0]  p;
    logic [CODE_W-1:0] c;
    p = second ? rd2_ptr : rd1_ptr;
    if (p == wr_ptr) return '0;
    c = ring[p];
    p = ring_next(p);
    if (second) rd2_ptr = p;
    else rd1_ptr = p;
    return c;
  endfunction

  function automatic result_t apply_request(request_t r);
    result_t           res;
    logic [CODE_W-1:0] base;
    res = '0;
    base = CODE_W'(3 * r.key);
    case (r.op)
      OP_SAMPLE: begin
        if (r.key < KEYS) begin
          if (r.down) begin
            if (!key_down[r.key]) begin
              key_down[r.key] = 1'b1;
              ring_push(base + CODE_PRESS);
              res.added++;
            end
            if (long_time_cfg != 0) begin
              if (hold_count[r.key] < long_time_cfg) begin
                hold_count[r.key]++;
                if (hold_count[r.key] == long_time_cfg) begin
                  ring_push(base + CODE_LONG);
                  res.added++;
                  long_presses++;
                end
              end else if (repeat_speed_cfg != 0) begin
                repeat_count[r.key]++;
                if (repeat_count[r.key] >= repeat_speed_cfg) begin
                  repeat_count[r.key] = '0;
                  ring_push(base + CODE_PRESS);
                  res.added++;
                  repeat_presses++;
                end
              end
            end
          end else begin
            if (key_down[r.key]) begin
              key_down[r.key] = 1'b0;
              ring_push(base + CODE_RELEASE);
              res.added++;
            end
            hold_count[r.key] = '0;
            repeat_count[r.key] = '0;
          end
          res.state = key_down[r.key];
        end
      end
      OP_POP1: res.code = ring_pop(1'b0);
      OP_POP2: res.code = ring_pop(1'b1);
      default: rd1_ptr = wr_ptr;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with none pending, key_code %0d", key_code));
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (key_code !== want.code)
            report_mismatch($sformatf("key_code %0d, want %0d", key_code, want.code));
          if (key_state !== want.state)
            report_mismatch($sformatf("key_state %0b, want %0b", key_state, want.state));
          if (events_added !== want.added)
            report_mismatch($sformatf("events_added %0d, want %0d", events_added, want.added));
        end
      end
      req_taken <= start && !busy;
      if (start && !busy)
        expected_results.push_back(apply_request(request_t'{op, key_index, pressed}));
    end
  end

  always @(negedge clk) begin
    request_t r;
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && !req_taken)) begin
      if (gap_left == 0 && idle_allowed && $urandom_range(0, 4) == 0)
        gap_left = $urandom_range(1, 13);
      if (gap_left > 0 || hold_sender || pending_requests.size() == 0) begin
        start <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        r = pending_requests.pop_front();
        start <= 1'b1;
        op <= r.op;
        key_index <= r.key;
        pressed <= r.down;
        requests_sent++;
      end
    end
  end

  function automatic void add_req(op_t o, int k, bit d);
    pending_requests.push_back(request_t'{o, 4'(k), d});
  endfunction

  function automatic void gen_random(int n, int hold_span);
    int   made;
    int   k;
    int   len;
    int   pick;
    op_t  o;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        k = $urandom_range(0, KEYS - 1);
        len = $urandom_range(1, hold_span);
        for (int i = 0; i < len; i++) begin
          add_req(OP_SAMPLE, k, 1'b1);
          made++;
          if ($urandom_range(0, 3) == 0) begin
            add_req(op_t'($urandom_range(1, 2)), $urandom_range(0, 15),
                    1'($urandom_range(0, 1)));
            made++;
          end
        end
        if ($urandom_range(0, 9) < 7) begin
          add_req(OP_SAMPLE, k, 1'b0);
          made++;
        end
      end else if (pick < 75) begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
          add_req(op_t'($urandom_range(1, 2)), $urandom_range(0, 15),
                  1'($urandom_range(0, 1)));
        made += len;
      end else if (pick < 80) begin
        add_req(OP_CLEAR, $urandom_range(0, 15), 1'($urandom_range(0, 1)));
        made++;
      end else begin
        o = op_t'($urandom_range(0, 3));
        k = $urandom_range(0, 15);
        add_req(o, k, 1'($urandom_range(0, 1)));
        if (!(o == OP_SAMPLE && k >= KEYS)) made++;
      end
    end
  endfunction

  task automatic settle();
    @(posedge clk);
    #1;
  endtask

  task automatic wait_quiet();
    while (start || expected_results.size() != 0 ||
           (!hold_sender && pending_requests.size() != 0))
      settle();
  endtask

  task automatic apb_write(logic idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_read(logic idx, output logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(logic [HOLD_W-1:0] lt, logic [REP_W-1:0] rs);
    logic [31:0] rd;
    apb_write(REG_LONG_TIME, {16'd0, lt});
    apb_write(REG_REPEAT_SPEED, {24'd0, rs});
    long_time_cfg = lt;
    repeat_speed_cfg = rs;
    foreach (repeat_count[i]) repeat_count[i] = '0;
    config_writes += 2;
    apb_read(REG_LONG_TIME, rd);
    if (rd !== {16'd0, lt})
      report_mismatch($sformatf("long_time reads %0d, want %0d", rd, lt));
    apb_read(REG_REPEAT_SPEED, rd);
    if (rd !== {24'd0, rs})
      report_mismatch($sformatf("repeat_speed reads %0d, want %0d", rd, rs));
  endtask

  initial begin
    int span;
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    add_req(OP_POP1, 0, 1'b0);
    add_req(OP_POP2, 15, 1'b1);
    add_req(OP_SAMPLE, 0, 1'b1);
    add_req(OP_SAMPLE, 12, 1'b1);
    add_req(OP_SAMPLE, 12, 1'b0);
    add_req(OP_SAMPLE, 13, 1'b1);
    add_req(OP_SAMPLE, 15, 1'b0);
    add_req(OP_SAMPLE, 0, 1'b0);
    add_req(OP_POP1, 0, 1'b0);
    add_req(OP_POP1, 0, 1'b0);
    add_req(OP_POP2, 0, 1'b0);
    add_req(OP_CLEAR, 0, 1'b0);
    add_req(OP_POP1, 0, 1'b0);
    repeat (3) add_req(OP_POP2, 0, 1'b0);
    gen_random(50, 40);
    wait_quiet();

    for (int ph = 0; ph < PHASES; ph++) begin
      set_config(HOLD_W'(phase_long_time[ph]), REP_W'(phase_repeat[ph]));
      idle_allowed = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
      if (ph == 0) begin
        repeat (3) add_req(OP_SAMPLE, 12, 1'b1);
        repeat (4) add_req(OP_POP1, 0, 1'b0);
        add_req(OP_SAMPLE, 12, 1'b0);
        repeat (2) add_req(OP_POP2, 0, 1'b0);
      end
      if (ph == LONG_HOLD_PHASE) begin
        for (int i = 0; i < 262; i++) begin
          add_req(OP_SAMPLE, 7, 1'b1);
          if (i % 16 == 15) add_req(OP_POP2, 0, 1'b0);
        end
        add_req(OP_SAMPLE, 7, 1'b0);
      end
      span = phase_long_time[ph] + 3 * phase_repeat[ph] + 3;
      if (span > 40) span = 40;
      gen_random(phase_items[ph], span);
      while (pending_requests.size() > phase_items[ph] / 2) settle();
      hold_sender = 1'b1;
      wait_quiet();
      hold_sender = 1'b0;
      wait_quiet();
    end

    repeat (10) @(posedge clk);
    $display("%0d requests over %0d register writes; %0d codes pushed, %0d long presses,",
             requests_sent, config_writes, codes_pushed, long_presses);
    $display("%0d repeated presses; %0d results checked, %0d mismatches",
             repeat_presses, results_checked, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
